>>> src/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that must never hold outside reset
`define ASSERT_NEVER(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

>>> src/pu_pkg.sv
// types and constants of the permutation unrank block
`timescale 1ns / 1ps

package pu_pkg;

    localparam int DATA_W     = 64;
    localparam int TERM_W     = 5;
    localparam int OUT_W      = 4;
    localparam int FACT_IDX_W = 5;
    localparam int FACT_SIZE  = 21;

    localparam logic [DATA_W-1:0] FACT [FACT_SIZE] = '{
        64'd1,
        64'd1,
        64'd2,
        64'd6,
        64'd24,
        64'd120,
        64'd720,
        64'd5040,
        64'd40320,
        64'd362880,
        64'd3628800,
        64'd39916800,
        64'd479001600,
        64'd6227020800,
        64'd87178291200,
        64'd1307674368000,
        64'd20922789888000,
        64'd355687428096000,
        64'd6402373705728000,
        64'd121645100408832000,
        64'd2432902008176640000
    };

    localparam logic [TERM_W-1:0] TERM_COUNT_RESET = 5'd16;
    localparam logic [DATA_W-1:0] RANK_LIMIT_RESET = 64'd20922789888000;

    localparam logic REG_TERM_COUNT = 1'b0;
    localparam logic REG_RANK_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_PICK,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic init;
        logic start;
        logic step;
    } div_ctrl_t;

    typedef struct packed {
        logic load;
        logic remove;
    } pool_ctrl_t;

endpackage

>>> src/permutation_unrank.sv
// permutation unrank top level: sequencer, config registers and result register
//
//  channel   signals                                   direction
//  request   in_valid, in_stall, rank                  in
//  result    out_valid, out_stall, element, position,  out
//            last, out_of_range
//  config    wr_en, wr_index, wr_data                  in
//
// a rank is loaded and range checked, then each element takes its own pass through
// divide, pick and send: QW quotient bits from the shared shift and subtract divider,
// one pick, one send (QW = 4 at the default size)
// a rejected rank goes from the check straight to send and gives one result
// in_stall stays high from acceptance until the last result is taken
// out_stall holds the result register and the sequencer until it drops
`timescale 1ns / 1ps
`include "assert_macros.svh"

module permutation_unrank #(
    parameter int MAX_TERMS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic                      wr_index,
    input  logic [pu_pkg::DATA_W-1:0] wr_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [pu_pkg::DATA_W-1:0] rank,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [pu_pkg::OUT_W-1:0]  element,
    output logic [pu_pkg::OUT_W-1:0]  position,
    output logic                      last,
    output logic                      out_of_range
);

    localparam int QW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW = $clog2(MAX_TERMS + 1);

    pu_pkg::state_t              state_reg;
    pu_pkg::state_t              state_next;
    logic [pu_pkg::TERM_W-1:0]   term_count_reg;
    logic [pu_pkg::DATA_W-1:0]   rank_limit_reg;
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic [QW-1:0]               pos_cnt_reg;
    logic [QW-1:0]               pos_cnt_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [pu_pkg::OUT_W-1:0]    element_reg;
    logic [pu_pkg::OUT_W-1:0]    element_next;
    logic [pu_pkg::OUT_W-1:0]    position_reg;
    logic [pu_pkg::OUT_W-1:0]    position_next;
    logic                        last_reg;
    logic                        last_next;
    logic                        oor_reg;
    logic                        oor_next;

    logic [CW-1:0]                 eff_n;
    logic [pu_pkg::FACT_IDX_W-1:0] fact_idx;
    logic [pu_pkg::DATA_W-1:0]     divisor;
    logic [QW-1:0]                 quotient;
    logic [pu_pkg::DATA_W-1:0]     div_rem;
    logic                          div_done;
    logic [QW-1:0]                 pick_idx;
    logic [QW-1:0]                 pool_entry;
    logic                          reject;
    pu_pkg::div_ctrl_t             div_ctrl;
    pu_pkg::pool_ctrl_t            pool_ctrl;

    // effective term count
    always_comb
    begin
        if (term_count_reg == '0)
        begin
            eff_n = CW'(1);
        end
        else if (term_count_reg > pu_pkg::TERM_W'(MAX_TERMS))
        begin
            eff_n = CW'(MAX_TERMS);
        end
        else
        begin
            eff_n = CW'(term_count_reg);
        end
    end

    always_comb
    begin
        if (count_reg == '0)
        begin
            fact_idx = '0;
        end
        else
        begin
            fact_idx = pu_pkg::FACT_IDX_W'(count_reg) - pu_pkg::FACT_IDX_W'(1);
        end
        divisor = pu_pkg::FACT[fact_idx];
        reject  = (div_rem >= rank_limit_reg)
               || (div_rem >= pu_pkg::FACT[pu_pkg::FACT_IDX_W'(eff_n)]);
        // guard against a quotient past the last unused entry
        if (CW'(quotient) >= count_reg)
        begin
            pick_idx = QW'(count_reg - CW'(1));
        end
        else
        begin
            pick_idx = quotient;
        end
    end

    pu_divider #(
        .QW (QW)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (rank),
        .divisor   (divisor),
        .quotient  (quotient),
        .remainder (div_rem),
        .done      (div_done)
    );

    pu_pool #(
        .DEPTH (MAX_TERMS),
        .EW    (QW)
    ) u_pool (
        .clk   (clk),
        .ctrl  (pool_ctrl),
        .idx   (pick_idx),
        .entry (pool_entry)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pu_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = pu_pkg::ST_CHECK;
                end
            end
            pu_pkg::ST_CHECK:
            begin
                state_next = reject ? pu_pkg::ST_SEND : pu_pkg::ST_DIVIDE;
            end
            pu_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = pu_pkg::ST_PICK;
                end
            end
            pu_pkg::ST_PICK:
            begin
                state_next = pu_pkg::ST_SEND;
            end
            pu_pkg::ST_SEND:
            begin
                if (!out_stall)
                begin
                    state_next = last_reg ? pu_pkg::ST_IDLE : pu_pkg::ST_DIVIDE;
                end
            end
            default:
            begin
                state_next = pu_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath control
    always_comb
    begin
        div_ctrl       = '0;
        pool_ctrl      = '0;
        count_next     = count_reg;
        pos_cnt_next   = pos_cnt_reg;
        out_valid_next = out_valid_reg;
        element_next   = element_reg;
        position_next  = position_reg;
        last_next      = last_reg;
        oor_next       = oor_reg;
        case (state_reg)
            pu_pkg::ST_IDLE:
            begin
                div_ctrl.init = in_valid;
            end
            pu_pkg::ST_CHECK:
            begin
                if (reject)
                begin
                    element_next   = '0;
                    position_next  = '0;
                    last_next      = 1'b1;
                    oor_next       = 1'b1;
                    out_valid_next = 1'b1;
                end
                else
                begin
                    pool_ctrl.load = 1'b1;
                    div_ctrl.start = 1'b1;
                    count_next     = eff_n;
                    pos_cnt_next   = '0;
                end
            end
            pu_pkg::ST_DIVIDE:
            begin
                div_ctrl.step = 1'b1;
            end
            pu_pkg::ST_PICK:
            begin
                pool_ctrl.remove = 1'b1;
                element_next     = pu_pkg::OUT_W'(pool_entry);
                position_next    = pu_pkg::OUT_W'(pos_cnt_reg);
                last_next        = (count_reg == CW'(1));
                oor_next         = 1'b0;
                out_valid_next   = 1'b1;
                count_next       = count_reg - CW'(1);
            end
            pu_pkg::ST_SEND:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (!last_reg)
                    begin
                        pos_cnt_next   = pos_cnt_reg + QW'(1);
                        div_ctrl.start = 1'b1;
                    end
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pu_pkg::ST_IDLE;
            term_count_reg <= pu_pkg::TERM_COUNT_RESET;
            rank_limit_reg <= pu_pkg::RANK_LIMIT_RESET;
            count_reg      <= '0;
            pos_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pos_cnt_reg   <= pos_cnt_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                case (wr_index)
                    pu_pkg::REG_TERM_COUNT:
                    begin
                        term_count_reg <= wr_data[pu_pkg::TERM_W-1:0];
                    end
                    pu_pkg::REG_RANK_LIMIT:
                    begin
                        rank_limit_reg <= wr_data;
                    end
                    default:
                    begin
                        rank_limit_reg <= rank_limit_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        element_reg  <= element_next;
        position_reg <= position_next;
        last_reg     <= last_next;
        oor_reg      <= oor_next;
    end

    assign in_stall     = (state_reg != pu_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign element      = element_reg;
    assign position     = position_reg;
    assign last         = last_reg;
    assign out_of_range = oor_reg;

    `ASSERT_CLK(a_valid_in_send, out_valid |-> (state_reg == pu_pkg::ST_SEND), "result outside send")
    `ASSERT_CLK(a_accept_check, (in_valid && !in_stall) |=> (state_reg == pu_pkg::ST_CHECK), "request not checked")
    `ASSERT_CLK(a_error_last, (out_valid && out_of_range) |-> last, "error result not last")
    `ASSERT_NEVER(a_count_range, (state_reg == pu_pkg::ST_DIVIDE) && ((count_reg == '0) || (count_reg > CW'(MAX_TERMS))), "pool count out of range")

endmodule

>>> src/pu_divider.sv
// shift and subtract divider, one quotient bit per cycle while ctrl.step is high
`timescale 1ns / 1ps

module pu_divider #(
    parameter int QW = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pu_pkg::div_ctrl_t         ctrl,
    input  logic [pu_pkg::DATA_W-1:0] dividend,
    input  logic [pu_pkg::DATA_W-1:0] divisor,
    output logic [QW-1:0]             quotient,
    output logic [pu_pkg::DATA_W-1:0] remainder,
    output logic                      done
);

    localparam int BW = (QW > 1) ? $clog2(QW) : 1;
    localparam int WW = pu_pkg::DATA_W + QW;

    logic [pu_pkg::DATA_W-1:0] rem_reg;
    logic [pu_pkg::DATA_W-1:0] rem_next;
    logic [QW-1:0]             quo_reg;
    logic [QW-1:0]             quo_next;
    logic [BW-1:0]             bit_reg;
    logic [BW-1:0]             bit_next;
    logic [WW-1:0]             shifted;
    logic                      fits;

    always_comb
    begin
        shifted  = {{QW{1'b0}}, divisor} << bit_reg;
        fits     = {{QW{1'b0}}, rem_reg} >= shifted;
        rem_next = rem_reg;
        quo_next = quo_reg;
        bit_next = bit_reg;
        if (ctrl.init)
        begin
            rem_next = dividend;
        end
        if (ctrl.start)
        begin
            quo_next = '0;
            bit_next = BW'(QW - 1);
        end
        else if (ctrl.step)
        begin
            if (fits)
            begin
                rem_next = rem_reg - shifted[pu_pkg::DATA_W-1:0];
                quo_next = quo_reg | (QW'(1) << bit_reg);
            end
            bit_next = bit_reg - BW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= '0;
        end
        else
        begin
            bit_reg <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = (bit_reg == '0);

endmodule

>>> src/pu_pool.sv
// pool of unused elements with load and remove at an index
`timescale 1ns / 1ps

module pu_pool #(
    parameter int DEPTH = 16,
    parameter int EW    = 4
) (
    input  logic               clk,
    input  pu_pkg::pool_ctrl_t ctrl,
    input  logic [EW-1:0]      idx,
    output logic [EW-1:0]      entry
);

    logic [EW-1:0] pool_reg  [DEPTH];
    logic [EW-1:0] pool_next [DEPTH];

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            pool_next[i] = pool_reg[i];
            if (ctrl.load)
            begin
                pool_next[i] = EW'(i);
            end
            else if (ctrl.remove && (i + 1 < DEPTH) && (i >= int'(idx)))
            begin
                pool_next[i] = pool_reg[(i + 1) % DEPTH];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            pool_reg[i] <= pool_next[i];
        end
    end

    assign entry = pool_reg[idx];

endmodule
